[sv/sirs_pkg.sv]
// Shared types, constants and the microcode table for the radix symbol converter.
// No dependencies; every other file imports this package.
package sirs_pkg;

  localparam int MaxBase   = 16;
  localparam int SymSlots  = 16;
  localparam int RadixCap  = (MaxBase < SymSlots) ? MaxBase : SymSlots;
  localparam int NumW      = 32;
  localparam int RadixW    = 5;
  localparam int DigitW    = 4;
  localparam int SymW      = 8;
  localparam int CfgW      = 64;
  localparam int AddrW     = 5;
  localparam int StackDep  = 32;
  localparam int StackIdxW = 5;
  localparam int SpW       = 6;
  localparam int UpcW      = 3;
  localparam int ChunkBits = 8;
  localparam int NumChunks = NumW / ChunkBits;
  localparam int ChunkW    = 2;

  localparam logic [SymW-1:0] ChMinus = 8'h2D;
  localparam logic [SymW-1:0] ChPlus  = 8'h2B;
  localparam logic [SymW-1:0] ChSpace = 8'h20;
  localparam logic [SymW-1:0] ChNul   = 8'h00;
  localparam logic [SymW-1:0] ChWsLo  = 8'd9;
  localparam logic [SymW-1:0] ChWsHi  = 8'd13;

  // register indexes (byte address bits [4:3])
  localparam logic [1:0] RegBase  = 2'd0;
  localparam logic [1:0] RegSymLo = 2'd1;
  localparam logic [1:0] RegSymHi = 2'd2;

  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t StWait  = 3'd0;
  localparam upc_t StCheck = 3'd1;
  localparam upc_t StSign  = 3'd2;
  localparam upc_t StMinus = 3'd3;
  localparam upc_t StDiv   = 3'd4;
  localparam upc_t StNext  = 3'd5;
  localparam upc_t StPop   = 3'd6;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_ALPH_OK,
    C_NEG,
    C_OUT_ROOM,
    C_CHUNK_LAST,
    C_MAG_NZ,
    C_POP_LAST
  } cond_t;

  // datapath controls, one bit each
  typedef struct packed {
    logic accept;
    logic load;
    logic div;
    logic push;
    logic emit_minus;
    logic pop;
  } ctl_t;

  // datapath status seen by the branch logic
  typedef struct packed {
    logic alph_ok;
    logic neg;
    logic out_room;
    logic chunk_last;
    logic mag_nz;
    logic pop_last;
  } stat_t;

  typedef struct packed {
    cond_t cond;
    upc_t  jt;
    upc_t  jf;
    ctl_t  ctl;
  } uword_t;

  localparam ctl_t CtlNone = '{default: 1'b0};

  // microprogram: branch to jt when cond holds, else jf
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{cond: C_ALWAYS, jt: StWait, jf: StWait, ctl: CtlNone};
    case (a)
      StWait: begin
        w.cond = C_IN_VALID; w.jt = StCheck; w.jf = StWait;
        w.ctl.accept = 1'b1; w.ctl.load = 1'b1;
      end
      StCheck: begin
        w.cond = C_ALPH_OK; w.jt = StSign; w.jf = StWait;
      end
      StSign: begin
        w.cond = C_NEG; w.jt = StMinus; w.jf = StDiv;
      end
      StMinus: begin
        w.cond = C_OUT_ROOM; w.jt = StDiv; w.jf = StMinus;
        w.ctl.emit_minus = 1'b1;
      end
      StDiv: begin
        w.cond = C_CHUNK_LAST; w.jt = StNext; w.jf = StDiv;
        w.ctl.div = 1'b1;
      end
      StNext: begin
        w.cond = C_MAG_NZ; w.jt = StDiv; w.jf = StPop;
        w.ctl.push = 1'b1;
      end
      StPop: begin
        w.cond = C_POP_LAST; w.jt = StWait; w.jf = StPop;
        w.ctl.pop = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS; w.jt = StWait; w.jf = StWait;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/sirs_cfg_regs.sv]
// APB register file (radix and alphabet) with the registered alphabet check.
// Depends on sirs_pkg.
module sirs_cfg_regs (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [sirs_pkg::AddrW-1:0]                 paddr,
  input  logic [sirs_pkg::CfgW-1:0]                  pwdata,
  output logic [sirs_pkg::CfgW-1:0]                  prdata,
  output logic                                       pready,
  output logic [sirs_pkg::RadixW-1:0]                radix,
  output logic [sirs_pkg::SymSlots-1:0][sirs_pkg::SymW-1:0] syms,
  output logic                                       alph_ok
);
  import sirs_pkg::*;

  logic [RadixW-1:0] base_r;
  logic [CfgW-1:0]   sym_lo_r;
  logic [CfgW-1:0]   sym_hi_r;
  logic              alph_ok_r;
  logic              alph_ok_nxt;
  logic [1:0]        idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      sym_lo_r  <= '0;
      sym_hi_r  <= '0;
      alph_ok_r <= 1'b0;
    end else begin
      alph_ok_r <= alph_ok_nxt;
      if (wr) begin
        unique case (idx)
          RegBase:  base_r   <= pwdata[RadixW-1:0];
          RegSymLo: sym_lo_r <= pwdata;
          RegSymHi: sym_hi_r <= pwdata;
          default:  ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      RegBase:  prdata = {{(CfgW-RadixW){1'b0}}, base_r};
      RegSymLo: prdata = sym_lo_r;
      RegSymHi: prdata = sym_hi_r;
      default:  prdata = '0;
    endcase
  end

  assign radix = (base_r > RadixW'(RadixCap)) ? RadixW'(RadixCap) : base_r;
  assign syms  = {sym_hi_r, sym_lo_r};

  // radix >= 2, no reserved byte, no repeats among the symbols in use
  always_comb begin
    logic [SymW-1:0] c;
    alph_ok_nxt = (radix >= RadixW'(2));
    for (int i = 0; i < SymSlots; i++) begin
      c = syms[i];
      if (RadixW'(i) < radix) begin
        if (c == ChNul || c == ChSpace || c == ChPlus || c == ChMinus ||
            (c >= ChWsLo && c <= ChWsHi))
          alph_ok_nxt = 1'b0;
        for (int j = i + 1; j < SymSlots; j++) begin
          if (RadixW'(j) < radix && syms[j] == c)
            alph_ok_nxt = 1'b0;
        end
      end
    end
  end

  assign alph_ok = alph_ok_r;

endmodule

[sv/sirs_seq.sv]
// Microcode sequencer: micro-PC, control ROM lookup and conditional branch.
// Depends on sirs_pkg.
module sirs_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  sirs_pkg::stat_t  stat,
  output sirs_pkg::ctl_t   ctl
);
  import sirs_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  uword_t uw;
  logic   take;

  assign uw  = ucode(upc_r);
  assign ctl = uw.ctl;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:     take = 1'b1;
      C_IN_VALID:   take = in_valid;
      C_ALPH_OK:    take = stat.alph_ok;
      C_NEG:        take = stat.neg;
      C_OUT_ROOM:   take = stat.out_room;
      C_CHUNK_LAST: take = stat.chunk_last;
      C_MAG_NZ:     take = stat.mag_nz;
      C_POP_LAST:   take = stat.out_room && stat.pop_last;
      default:      take = 1'b0;
    endcase
    upc_nxt = take ? uw.jt : uw.jf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= StWait;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[sv/sirs_datapath.sv]
// Datapath: magnitude/quotient register, 8-bit-per-cycle divider, digit stack
// and the registered output stage. Depends on sirs_pkg.
module sirs_datapath (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  sirs_pkg::ctl_t                             ctl,
  output sirs_pkg::stat_t                            stat,
  input  logic                                       in_valid,
  input  logic signed [sirs_pkg::NumW-1:0]           in_number,
  input  logic [sirs_pkg::RadixW-1:0]                radix,
  input  logic [sirs_pkg::SymSlots-1:0][sirs_pkg::SymW-1:0] syms,
  input  logic                                       alph_ok,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [sirs_pkg::SymW-1:0]                  out_symbol,
  output logic                                       out_last
);
  import sirs_pkg::*;

  logic [NumW-1:0]   mag_r;
  logic [NumW-1:0]   mag_nxt;
  logic [DigitW-1:0] rem_r;
  logic [DigitW-1:0] rem_nxt;
  logic              neg_r;
  logic [ChunkW-1:0] chunk_r;
  logic [SpW-1:0]    sp_r;
  logic [SpW-1:0]    sp_dec;
  logic [DigitW-1:0] stack_r [StackDep];
  logic              out_valid_r;
  logic [SymW-1:0]   out_symbol_r;
  logic              out_last_r;
  logic              room;
  logic [NumW-1:0]   raw;
  logic [DigitW-1:0] top_digit;

  assign raw       = in_number;
  assign room      = !out_valid_r || !out_stall;
  assign sp_dec    = sp_r - 1'b1;
  assign top_digit = stack_r[sp_dec[StackIdxW-1:0]];

  // restoring division: eight quotient bits per cycle, quotient shifts into mag
  always_comb begin
    logic [DigitW:0] t;
    rem_nxt = rem_r;
    mag_nxt = mag_r;
    for (int k = 0; k < ChunkBits; k++) begin
      t       = {rem_nxt, mag_nxt[NumW-1]};
      mag_nxt = {mag_nxt[NumW-2:0], 1'b0};
      if (t >= radix) begin
        rem_nxt    = DigitW'(t - radix);
        mag_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[DigitW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r     <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.load && in_valid) begin
        neg_r <= raw[NumW-1];
        mag_r <= raw[NumW-1] ? (~raw + 1'b1) : raw;
        rem_r <= '0;
        sp_r  <= '0;
      end
      if (ctl.div) begin
        mag_r   <= mag_nxt;
        rem_r   <= rem_nxt;
        chunk_r <= chunk_r + 1'b1;
      end
      if (ctl.push) begin
        stack_r[sp_r[StackIdxW-1:0]] <= rem_r;
        sp_r  <= sp_r + 1'b1;
        rem_r <= '0;
      end

      if (ctl.emit_minus && room) begin
        out_valid_r  <= 1'b1;
        out_symbol_r <= ChMinus;
        out_last_r   <= 1'b0;
      end else if (ctl.pop && room) begin
        out_valid_r  <= 1'b1;
        out_symbol_r <= syms[top_digit];
        out_last_r   <= (sp_r == SpW'(1));
        sp_r         <= sp_dec;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.alph_ok    = alph_ok;
  assign stat.neg        = neg_r;
  assign stat.out_room   = room;
  assign stat.chunk_last = (chunk_r == ChunkW'(NumChunks - 1));
  assign stat.mag_nz     = (mag_r != '0);
  assign stat.pop_last   = (sp_r == SpW'(1));

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

[sv/signed_int_to_radix_symbols.sv]
// Top level of the signed integer to radix symbol converter.
// Depends on sirs_pkg, sirs_cfg_regs, sirs_seq and sirs_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_number): one signed 32-bit
//   request per number. in_stall is low only while the sequencer waits for
//   work, so one number is converted at a time.
//   Output channel (out_valid / out_stall / out_symbol / out_last): a '-'
//   for negative numbers, then the digits most significant first; out_last
//   marks the final digit. Numbers with a bad alphabet produce nothing.
//   Config: APB, 64-bit data; radix at 0x00, symbols 0..7 at 0x08,
//   symbols 8..15 at 0x10. Write only while idle.
// Operation (a number has at most 32 digits): after a request is taken the
//   alphabet is checked and a rejected alphabet ends the number; otherwise
//   a '-' is sent for a negative number. Each digit takes 4 divider passes
//   (8 quotient bits per pass) plus a push onto the digit stack, and one
//   pop to send it.
// Reset (rst_n, synchronous): clears config registers to zero, sequencer to
//   wait, output empty. A stall on the output holds the result register and
//   freezes the sequencer in its current send step; the next request is
//   taken while the last symbol still sits in the output register.
module signed_int_to_radix_symbols (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sirs_pkg::NumW-1:0]  in_number,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sirs_pkg::SymW-1:0]         out_symbol,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sirs_pkg::AddrW-1:0]        paddr,
  input  logic [sirs_pkg::CfgW-1:0]         pwdata,
  output logic [sirs_pkg::CfgW-1:0]         prdata,
  output logic                              pready
);
  import sirs_pkg::*;

  ctl_t                         ctl;
  stat_t                        stat;
  logic [RadixW-1:0]            radix;
  logic [SymSlots-1:0][SymW-1:0] syms;
  logic                         alph_ok;

  // request taken only in the wait step of the microprogram
  assign in_stall = !ctl.accept;

  sirs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix   (radix),
    .syms    (syms),
    .alph_ok (alph_ok)
  );

  sirs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  sirs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_valid   (in_valid),
    .in_number  (in_number),
    .radix      (radix),
    .syms       (syms),
    .alph_ok    (alph_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

endmodule

[sv/sirs_checker.sv]
// Port-level checks for signed_int_to_radix_symbols, attached by bind.
// Depends on sirs_pkg.
module sirs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [sirs_pkg::SymW-1:0] out_symbol,
  input logic                      out_last
);
  import sirs_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("stalled output changed");

  // one number at a time: no back-to-back requests
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // the sign is never the final symbol
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol == ChMinus |-> !out_last)
    else $error("minus sign flagged last");

endmodule

bind signed_int_to_radix_symbols sirs_checker u_sirs_checker (.*);
